/* rtl/mxt_pkg.sv */
package mxt_pkg;

  localparam int unsigned ValueBits  = 31;
  localparam int unsigned MaxNumbers = 1024;
  localparam int unsigned MaxNodes   = 32768;
  localparam int unsigned NodeW      = $clog2(MaxNodes);
  localparam int unsigned NumW       = $clog2(MaxNumbers);
  localparam int unsigned LevelW     = $clog2(ValueBits);
  localparam int unsigned LinkW      = 2 * NodeW;

  typedef struct packed {
    logic [ValueBits-1:0] value;
    logic                 last;
  } req_t;

  typedef struct packed {
    logic [ValueBits-1:0] max_xor;
    logic                 overflowed;
  } rsp_t;

  typedef enum logic [10:0] {
    StIdle   = 11'b00000000001,
    StProbe  = 11'b00000000010,
    StProbeW = 11'b00000000100,
    StIns    = 11'b00000001000,
    StInsW   = 11'b00000010000,
    StNumRd  = 11'b00000100000,
    StNumW   = 11'b00001000000,
    StWalk   = 11'b00010000000,
    StWalkW  = 11'b00100000000,
    StNext   = 11'b01000000000,
    StOut    = 11'b10000000000
  } state_e;

  typedef struct packed {
    logic load;
    logic probe_start;
    logic probe_step;
    logic ins_start;
    logic ins_step;
    logic store_num;
    logic search_start;
    logic num_read;
    logic walk_start;
    logic walk_step;
    logic walk_done;
    logic set_overflow;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic level_zero;
    logic probe_miss;
    logic store_full;
    logic no_room;
    logic more_numbers;
    logic is_last;
  } sts_t;

endpackage

/* rtl/mxt_ram.sv */
module mxt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

/* rtl/mxt_datapath.sv */
module mxt_datapath (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  mxt_pkg::req_t req_i,
  input  mxt_pkg::cmd_t cmd_i,
  output mxt_pkg::sts_t sts_o,
  output mxt_pkg::rsp_t rsp_o
);
  localparam int unsigned VB = mxt_pkg::ValueBits;
  localparam int unsigned NW = mxt_pkg::NodeW;

  logic [VB-1:0] val_q;
  logic last_q;
  logic [mxt_pkg::LevelW-1:0] lvl_q;
  logic [NW-1:0] node_q;
  logic [NW:0] used_q;
  logic [mxt_pkg::NumW:0] held_q, idx_q;
  logic ovf_q;
  logic [VB-1:0] num_q, leaf_q, best_q;
  logic [mxt_pkg::LevelW:0] need_q;
  logic [NW-1:0] root0_q, root1_q;
  // a freshly allocated node reads as empty: flag via the allocation tracking
  logic fresh_q;

  logic [mxt_pkg::LinkW-1:0] rd_raw, link, lk_wdata;
  logic lk_we;
  logic [NW-1:0] lk_waddr, lk_raddr, c0, c1;
  logic [VB-1:0] st_rdata;
  logic cur_bit, wbit, took;
  logic [NW-1:0] nxt;
  logic [NW-1:0] newn;
  logic [VB-1:0] cand;

  // root links live in flops so a clear can reset them directly
  assign link = (node_q == '0) ? {root1_q, root0_q} : rd_raw;
  assign c0 = link[NW-1:0];
  assign c1 = link[mxt_pkg::LinkW-1:NW];
  assign cur_bit = val_q[lvl_q];
  assign wbit = num_q[lvl_q];
  assign newn = used_q[NW-1:0];

  always_comb begin
    lk_raddr = node_q;
    lk_we = 1'b0;
    lk_waddr = node_q;
    lk_wdata = fresh_q ? '0 : link;
    if (cmd_i.ins_step) begin
      lk_we = 1'b1;
      if (fresh_q || (cur_bit ? c1 : c0) == '0) begin
        if (cur_bit) lk_wdata[mxt_pkg::LinkW-1:NW] = newn;
        else lk_wdata[NW-1:0] = newn;
      end
    end
  end

  assign nxt = cur_bit ? c1 : c0;

  mxt_ram #(.Width(mxt_pkg::LinkW), .Depth(mxt_pkg::MaxNodes)) u_links (
    .clk_i, .we_i(lk_we && node_q != '0), .waddr_i(lk_waddr), .wdata_i(lk_wdata),
    .raddr_i(lk_raddr), .rdata_o(rd_raw)
  );

  mxt_ram #(.Width(VB), .Depth(mxt_pkg::MaxNumbers)) u_store (
    .clk_i, .we_i(cmd_i.store_num), .waddr_i(held_q[mxt_pkg::NumW-1:0]), .wdata_i(val_q),
    .raddr_i(idx_q[mxt_pkg::NumW-1:0]), .rdata_o(st_rdata)
  );

  logic [NW-1:0] wnext;

  always_comb begin
    took = ~wbit;
    wnext = took ? c1 : c0;
    if (wnext == '0) begin
      took = wbit;
      wnext = took ? c1 : c0;
    end
    if (wnext == '0) took = 1'b0;
  end

  assign cand = num_q ^ {leaf_q[VB-1:1], took};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= (NW+1)'(1);
      held_q <= '0;
      ovf_q <= 1'b0;
      root0_q <= '0;
      root1_q <= '0;
      fresh_q <= 1'b0;
    end else begin
      if (cmd_i.set_overflow) ovf_q <= 1'b1;
      if (cmd_i.store_num) held_q <= held_q + 1'b1;
      if (cmd_i.ins_step) begin
        if (node_q == '0) begin
          root0_q <= lk_wdata[NW-1:0];
          root1_q <= lk_wdata[mxt_pkg::LinkW-1:NW];
        end
        if (nxt == '0 || fresh_q) used_q <= used_q + 1'b1;
        fresh_q <= (nxt == '0) || fresh_q;
      end
      if (cmd_i.ins_start) fresh_q <= 1'b0;
      if (cmd_i.clear) begin
        used_q <= (NW+1)'(1);
        held_q <= '0;
        ovf_q <= 1'b0;
        root0_q <= '0;
        root1_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      val_q <= req_i.value;
      last_q <= req_i.last;
    end
    if (cmd_i.probe_start || cmd_i.ins_start || cmd_i.walk_start) begin
      lvl_q <= mxt_pkg::LevelW'(VB-1);
      node_q <= '0;
      need_q <= '0;
    end
    if (cmd_i.probe_step) begin
      if (nxt == '0) need_q <= {1'b0, lvl_q} + 1'b1;
      else begin
        node_q <= nxt;
        lvl_q <= lvl_q - 1'b1;
      end
    end
    if (cmd_i.ins_step) begin
      node_q <= (nxt == '0 || fresh_q) ? newn : nxt;
      lvl_q <= lvl_q - 1'b1;
    end
    if (cmd_i.walk_step) begin
      if (wnext != '0) node_q <= wnext;
      leaf_q[lvl_q] <= took;
      lvl_q <= lvl_q - 1'b1;
    end
    if (cmd_i.search_start) begin
      idx_q <= '0;
      best_q <= '0;
    end
    if (cmd_i.num_read) num_q <= st_rdata;
    if (cmd_i.walk_done) begin
      if (cand > best_q) best_q <= cand;
      idx_q <= idx_q + 1'b1;
    end
  end

  // probe stops at a miss; level_zero marks the final level
  assign sts_o.level_zero = (lvl_q == '0);
  assign sts_o.probe_miss = (nxt == '0);
  assign sts_o.store_full = (held_q >= (mxt_pkg::NumW+1)'(mxt_pkg::MaxNumbers));
  assign sts_o.no_room = (32'(need_q) > 32'(mxt_pkg::MaxNodes) - 32'(used_q));
  assign sts_o.more_numbers = (idx_q < held_q);
  assign sts_o.is_last = last_q;
  assign rsp_o.max_xor = best_q;
  assign rsp_o.overflowed = ovf_q;
endmodule

/* rtl/mxt_ctrl.sv */
module mxt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  output logic          rsp_valid_o,
  input  logic          rsp_ready_i,
  input  mxt_pkg::sts_t sts_i,
  output mxt_pkg::cmd_t cmd_o
);
  mxt_pkg::state_e state_q, state_d;
  logic probe_hit_q, probe_hit_d;

  assign req_ready_o = (state_q == mxt_pkg::StIdle);
  assign rsp_valid_o = (state_q == mxt_pkg::StOut);

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    probe_hit_d = probe_hit_q;
    unique case (state_q)
      mxt_pkg::StIdle: begin
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          cmd_o.probe_start = 1'b1;
          state_d = mxt_pkg::StProbe;
        end
      end
      // link read latency: StProbe waits for the registered link read at each level
      mxt_pkg::StProbe: state_d = mxt_pkg::StProbeW;
      mxt_pkg::StProbeW: begin
        if (sts_i.store_full) begin
          cmd_o.set_overflow = 1'b1;
          state_d = mxt_pkg::StNumRd;
        end else begin
          cmd_o.probe_step = 1'b1;
          if (sts_i.probe_miss || sts_i.level_zero) state_d = mxt_pkg::StIns;
          else state_d = mxt_pkg::StProbe;
        end
      end
      mxt_pkg::StIns: begin
        if (sts_i.no_room) begin
          cmd_o.set_overflow = 1'b1;
          state_d = mxt_pkg::StNumRd;
        end else begin
          cmd_o.ins_start = 1'b1;
          state_d = mxt_pkg::StInsW;
        end
      end
      mxt_pkg::StInsW: begin
        cmd_o.ins_step = 1'b1;
        if (sts_i.level_zero) begin
          cmd_o.store_num = 1'b1;
          state_d = mxt_pkg::StNumRd;
        end else state_d = mxt_pkg::StNumW;
      end
      mxt_pkg::StNumW: state_d = mxt_pkg::StInsW;
      mxt_pkg::StNumRd: begin
        if (!sts_i.is_last) state_d = mxt_pkg::StIdle;
        else begin
          cmd_o.search_start = 1'b1;
          state_d = mxt_pkg::StNext;
        end
      end
      mxt_pkg::StNext: begin
        if (sts_i.more_numbers) state_d = mxt_pkg::StWalk;
        else state_d = mxt_pkg::StOut;
      end
      mxt_pkg::StWalk: begin
        cmd_o.num_read = 1'b1;
        cmd_o.walk_start = 1'b1;
        state_d = mxt_pkg::StWalkW;
        probe_hit_d = 1'b0;
      end
      mxt_pkg::StWalkW: begin
        if (!probe_hit_q) probe_hit_d = 1'b1;
        else begin
          probe_hit_d = 1'b0;
          cmd_o.walk_step = 1'b1;
          if (sts_i.level_zero) begin
            cmd_o.walk_done = 1'b1;
            state_d = mxt_pkg::StNext;
          end
        end
      end
      mxt_pkg::StOut: begin
        if (rsp_ready_i) begin
          cmd_o.clear = 1'b1;
          state_d = mxt_pkg::StIdle;
        end
      end
      default: state_d = mxt_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mxt_pkg::StIdle;
      probe_hit_q <= 1'b0;
    end else begin
      state_q <= state_d;
      probe_hit_q <= probe_hit_d;
    end
  end
endmodule

/* rtl/max_xor_pair_trie_unit.sv */
// Finds the largest XOR of any two numbers in a set. Each request carries
// one 31-bit number; it is first looked up in a binary trie held in a link
// RAM and then inserted, each pass waiting on the registered RAM read at
// every trie level. On the request marked last, every stored number walks
// the trie level by level, then one response gives the maximum and an
// overflow flag; the block clears itself when the response is taken.
// Numbers past 1024 or needing nodes past 32768 are dropped and flagged.
module max_xor_pair_trie_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  mxt_pkg::req_t req_i,
  output logic          rsp_valid_o,
  input  logic          rsp_ready_i,
  output mxt_pkg::rsp_t rsp_o
);
  mxt_pkg::cmd_t cmd;
  mxt_pkg::sts_t sts;

  mxt_ctrl u_ctrl (
    .clk_i, .rst_ni, .req_valid_i, .req_ready_o, .rsp_valid_o, .rsp_ready_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  mxt_datapath u_dp (
    .clk_i, .rst_ni, .req_i, .cmd_i(cmd), .sts_o(sts), .rsp_o
  );
endmodule

/* rtl/mxt_checker.sv */
module mxt_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          req_valid_i,
  input logic          req_ready_o,
  input logic          rsp_valid_o,
  input logic          rsp_ready_i,
  input mxt_pkg::rsp_t rsp_o
);
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_ready_o && rsp_valid_o)) else $error("ready while response pending");
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_ready_i |=> rsp_valid_o && $stable(rsp_o))
    else $error("response changed while stalled");
  a_idle_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_ready_i |=> req_ready_o) else $error("not idle after response");
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_o |=> !req_ready_o) else $error("ready right after request");
endmodule

bind max_xor_pair_trie_unit mxt_checker u_chk (
  .clk_i, .rst_ni, .req_valid_i, .req_ready_o, .rsp_valid_o, .rsp_ready_i, .rsp_o
);
